// ----- design/mcpc_pkg.sv -----
// Package for the multi-channel press classifier: widths, codes and register map.
`default_nettype none

package mcpc_pkg;

    localparam int CHANNELS  = 16;
    localparam int CHAN_BITS = 4;
    localparam int TIME_BITS = 32;
    localparam int THR_BITS  = 16;
    localparam int KIND_BITS = 2;

    localparam int S_DATA_BITS = 40;  // channel, level, now_ms padded to bytes
    localparam int M_DATA_BITS = 8;   // event_channel, event_kind padded
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [THR_BITS-1:0] SHORT_THR_RESET = 16'd60;
    localparam logic [THR_BITS-1:0] LONG_THR_RESET  = 16'd500;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_SHORT_THR = 1'b0,
        REG_LONG_THR  = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_PUSH = 2'd1,
        PHASE_HOLD = 2'd2
    } t_phase;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_SHORT_RELEASE = 2'd0,
        KIND_HOLD_BEGIN    = 2'd1,
        KIND_HOLD_RELEASE  = 2'd2
    } t_kind;

endpackage

`default_nettype wire

// ----- design/multi_channel_press_classifier_top.sv -----
// Top level of the multi-channel press classifier: input stage, channel state, result register.
//
//  channel  | dir | handshake              | contents
//  ---------+-----+------------------------+---------------------------------------------
//  s (in)   | in  | i_s_tvalid/o_s_tready  | one sample: channel, level, now_ms
//  m (out)  | out | o_m_tvalid/i_m_tready  | one event: event_channel, event_kind
//  apb      | in  | psel/penable/pready    | short/long thresholds at 0x0 / 0x4
//
// Timing: a sample is held in the input register, is classified there and its
// event (if any) lands in the result register when the stage advances; one sample
// per cycle sustained while the sink keeps up. The per-channel state read/modify/write happens in
// that one stage, so back-to-back samples on the same channel see the update.
// Reset (synchronous, active low) clears both valid flags, all press-recorded bits and
// phases, and loads the thresholds with 60 and 500 ms.
// Stalls: the stage advances while the result register is empty or being drained;
// o_s_tready follows that, so with the sink held off and an event waiting, one more
// item is taken into the input register and then the source stalls.
`default_nettype none

module multi_channel_press_classifier_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // slave stream
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    // [3:0] channel, [4] level, [36:5] now_ms, [39:37] zero
    input  wire logic [mcpc_pkg::S_DATA_BITS-1:0]     i_s_tdata,
    // master stream
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    // [3:0] event_channel, [5:4] event_kind, [7:6] zero
    output logic [mcpc_pkg::M_DATA_BITS-1:0]          o_m_tdata,
    // configuration
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mcpc_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [mcpc_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [mcpc_pkg::APB_DATA_BITS-1:0]        prdata,
    output logic                                      pready
);

    localparam int CB = mcpc_pkg::CHAN_BITS;
    localparam int TB = mcpc_pkg::TIME_BITS;
    localparam int HB = mcpc_pkg::THR_BITS;

    // ---------------- configuration registers ----------------
    logic [HB-1:0] r_short_thr;
    logic [HB-1:0] r_long_thr;
    logic          cfg_wr;
    mcpc_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = mcpc_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_thr <= mcpc_pkg::SHORT_THR_RESET;
            r_long_thr  <= mcpc_pkg::LONG_THR_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                mcpc_pkg::REG_SHORT_THR: r_short_thr <= pwdata[HB-1:0];
                mcpc_pkg::REG_LONG_THR:  r_long_thr  <= pwdata[HB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            mcpc_pkg::REG_SHORT_THR: prdata = {{(mcpc_pkg::APB_DATA_BITS-HB){1'b0}}, r_short_thr};
            mcpc_pkg::REG_LONG_THR:  prdata = {{(mcpc_pkg::APB_DATA_BITS-HB){1'b0}}, r_long_thr};
            default:                 prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    logic          r_in_valid;
    logic [CB-1:0] r_in_ch;
    logic          r_in_level;
    logic [TB-1:0] r_in_now;

    logic r_out_valid;
    logic advance;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_ch    <= i_s_tdata[CB-1:0];
            r_in_level <= i_s_tdata[CB];
            r_in_now   <= i_s_tdata[CB+TB:CB+1];
        end
    end

    // ---------------- per-channel state ----------------
    logic [TB-1:0]        r_start [mcpc_pkg::CHANNELS];
    logic                 r_rec   [mcpc_pkg::CHANNELS];
    mcpc_pkg::t_phase     r_phase [mcpc_pkg::CHANNELS];

    mcpc_pkg::t_phase cur_phase;
    mcpc_pkg::t_phase armed_phase;
    mcpc_pkg::t_phase n_phase;
    logic             cur_rec;
    logic             n_rec;
    logic             start_we;
    logic             st_we;
    logic             ch_ok;
    logic [TB-1:0]    elapsed;
    logic             ge_short;
    logic             ge_long;
    logic             hit;
    mcpc_pkg::t_kind  hit_kind;

    assign ch_ok     = ({1'b0, r_in_ch} < (CB+1)'(mcpc_pkg::CHANNELS));
    assign cur_phase = r_phase[r_in_ch];
    assign cur_rec   = r_rec[r_in_ch];

    // elapsed time wraps with the timestamp
    assign elapsed  = r_in_now - r_start[r_in_ch];
    assign ge_short = (|elapsed[TB-1:HB]) || (elapsed[HB-1:0] >= r_short_thr);
    assign ge_long  = (|elapsed[TB-1:HB]) || (elapsed[HB-1:0] >= r_long_thr);

    always_comb begin
        n_phase     = cur_phase;
        n_rec       = cur_rec;
        start_we    = 1'b0;
        hit         = 1'b0;
        hit_kind    = mcpc_pkg::KIND_SHORT_RELEASE;
        armed_phase = cur_phase;
        if (!r_in_level) begin
            if (!cur_rec) begin
                // first low sample only stamps the press start
                start_we = 1'b1;
                n_rec    = 1'b1;
            end else begin
                if (ge_short && cur_phase == mcpc_pkg::PHASE_IDLE) begin
                    armed_phase = mcpc_pkg::PHASE_PUSH;
                end
                n_phase = armed_phase;
                // both thresholds may pass on the same sample
                if (ge_long && armed_phase == mcpc_pkg::PHASE_PUSH) begin
                    n_phase  = mcpc_pkg::PHASE_HOLD;
                    hit      = 1'b1;
                    hit_kind = mcpc_pkg::KIND_HOLD_BEGIN;
                end
            end
        end else begin
            n_rec   = 1'b0;
            n_phase = mcpc_pkg::PHASE_IDLE;
            case (cur_phase)
                mcpc_pkg::PHASE_HOLD: begin
                    hit      = 1'b1;
                    hit_kind = mcpc_pkg::KIND_HOLD_RELEASE;
                end
                mcpc_pkg::PHASE_PUSH: begin
                    hit      = 1'b1;
                    hit_kind = mcpc_pkg::KIND_SHORT_RELEASE;
                end
                default: ;
            endcase
        end
    end

    assign st_we = advance && ch_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mcpc_pkg::CHANNELS; i++) begin
                r_rec[i]   <= 1'b0;
                r_phase[i] <= mcpc_pkg::PHASE_IDLE;
            end
        end else if (st_we) begin
            r_rec[r_in_ch]   <= n_rec;
            r_phase[r_in_ch] <= n_phase;
        end
    end

    // start time is only read while its recorded bit is set
    always_ff @(posedge i_clk) begin
        if (st_we && start_we) begin
            r_start[r_in_ch] <= r_in_now;
        end
    end

    // ---------------- result register ----------------
    logic [CB-1:0]   r_out_ch;
    mcpc_pkg::t_kind r_out_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= hit && ch_ok;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_ch   <= r_in_ch;
            r_out_kind <= hit_kind;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(mcpc_pkg::M_DATA_BITS-CB-mcpc_pkg::KIND_BITS){1'b0}},
                         r_out_kind, r_out_ch};

endmodule

`default_nettype wire
